// File: hw/rtl/srpb_pkg.sv
// ============================================================================
// srpb_pkg: shared definitions for the sparse row pattern builder
// Field widths, parameter defaults, the insert command code and the address width helper.
// ============================================================================
package srpb_pkg;

    localparam int ROWS_DEF        = 1024;
    localparam int MAX_PER_ROW_DEF = 32;

    localparam int ROW_W = 10;
    localparam int COL_W = 16;
    localparam int POS_W = 5;
    localparam int CNT_W = 16;

    localparam logic CMD_INSERT = 1'b0;

    typedef logic [COL_W-1:0] t_col;
    typedef logic [CNT_W-1:0] t_count;

    // Address bits for a store of the given depth, never less than one.
    function automatic int addr_w(int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

// File: hw/rtl/srpb_ram.sv
// ============================================================================
// srpb_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module srpb_ram import srpb_pkg::*; #(
    parameter int WIDTH = COL_W,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [addr_w(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [addr_w(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sparse_row_pattern_builder.sv
// ============================================================================
// sparse_row_pattern_builder: sorted per-row column index store
// Keeps an ascending, duplicate-free list of columns for each row and a
// running count of distinct entries. Insert places a column in sorted order;
// search returns its position within the row.
// ============================================================================
// The input stalls from accept until the result is loaded into the output
// register; meanwhile the sequencer walks the columns stored in the row
// (0..MAX_PER_ROW of them) in the column RAM; out-of-range rows skip the walk.
// Reset: synchronous, active low; afterwards a clearing pass over every row
// zeroes the row length RAM while the input stays stalled.
module sparse_row_pattern_builder import srpb_pkg::*; #(
    parameter int ROWS        = ROWS_DEF,
    parameter int MAX_PER_ROW = MAX_PER_ROW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [ROW_W-1:0]   i_row,
    input  t_col               i_column,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic [POS_W-1:0]   o_position,
    output logic               o_row_full,
    output t_count             o_nonzero_count
);

    // Row length width holds 0..MAX_PER_ROW.
    localparam int LW     = $clog2(MAX_PER_ROW + 1);
    localparam int LAW    = addr_w(ROWS);
    localparam int XW     = (LAW > ROW_W) ? LAW : ROW_W;
    localparam int CDEPTH = ROWS * MAX_PER_ROW;
    localparam int CAW    = addr_w(CDEPTH);
    localparam int XPW    = (LW > POS_W) ? LW : POS_W;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // zero the length RAM after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;  // wait for a transaction
    localparam logic [2:0] ST_LEN   = 3'd2;  // row length arrives from RAM
    localparam logic [2:0] ST_SCAN  = 3'd3;  // walk stored columns in order
    localparam logic [2:0] ST_SHIFT = 3'd4;  // ripple displaced columns up
    localparam logic [2:0] ST_TAIL  = 3'd5;  // write last slot, bump length
    localparam logic [2:0] ST_DONE  = 3'd6;  // hand result to output register

    logic [2:0]      r_state, n_state;
    logic [LAW-1:0]  r_clr, n_clr;
    logic            r_cmd, n_cmd;
    logic [LAW-1:0]  r_row, n_row;
    t_col            r_col, n_col;
    logic [CAW-1:0]  r_base, n_base;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_idx, n_idx;
    logic [LW-1:0]   r_pos, n_pos;
    t_col            r_carry, n_carry;
    t_count          r_count, n_count;
    logic            r_res_found, n_res_found;
    logic [LW-1:0]   r_res_pos, n_res_pos;
    logic            r_res_full, n_res_full;

    logic             r_out_valid;
    logic             r_out_found;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_full;
    t_count           r_out_count;

    logic            in_acc;
    logic            out_load;
    logic [XW-1:0]   row_x;
    logic            row_in_range;
    logic [LW-1:0]   len_rdata;
    t_col            col_rdata;
    logic [LW-1:0]   idx1;
    logic            last;
    logic            row_is_full;
    logic            is_ins;
    logic [LW-1:0]   rd_idx;
    logic [CAW-1:0]  col_raddr;
    logic [CAW-1:0]  col_waddr;
    logic            col_we;
    t_col            col_wdata;
    logic            len_we;
    logic [LAW-1:0]  len_waddr;
    logic [LW-1:0]   len_wdata;
    logic [XPW-1:0]  pos_x;

    // Accept input only when the sequencer is free; the output register
    // decouples a waiting result from the next transaction.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    assign row_x        = XW'(i_row);
    assign row_in_range = (32'(i_row) < 32'(ROWS));

    assign idx1        = r_idx + LW'(1);
    assign last        = (idx1 == r_len);
    assign row_is_full = (r_len == LW'(MAX_PER_ROW));
    assign is_ins      = (r_cmd == CMD_INSERT);

    assign col_raddr = r_base + CAW'(rd_idx);
    assign col_waddr = r_base + CAW'(r_idx);

    // Row length store: one entry per row, cleared by the sweep after reset.
    // Its read address follows the input row so the length is ready the
    // cycle after accept.
    srpb_ram #(
        .WIDTH (LW),
        .DEPTH (ROWS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (row_x[LAW-1:0]),
        .o_rdata (len_rdata)
    );

    // Column store: MAX_PER_ROW slots per row, only the first r_len are live.
    srpb_ram #(
        .WIDTH (COL_W),
        .DEPTH (CDEPTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_len       = r_len;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_carry     = r_carry;
        n_count     = r_count;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_res_full  = r_res_full;
        rd_idx      = idx1;
        col_we      = 1'b0;
        col_wdata   = r_carry;
        len_we      = 1'b0;
        len_waddr   = r_row;
        len_wdata   = r_len + LW'(1);

        unique case (r_state)
            ST_CLEAR: begin
                // Sweep every row length to zero, one entry per cycle.
                len_we    = 1'b1;
                len_waddr = r_clr;
                len_wdata = '0;
                n_clr     = r_clr + LAW'(1);
                if (r_clr == LAW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd       = i_command;
                    n_row       = row_x[LAW-1:0];
                    n_col       = i_column;
                    n_base      = CAW'(row_x * MAX_PER_ROW);
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_res_full  = 1'b0;
                    // Drop rows beyond the store: report zeros and the count.
                    n_state     = row_in_range ? ST_LEN : ST_DONE;
                end
            end
            ST_LEN: begin
                // Length is here; start the walk at slot zero.
                n_len  = len_rdata;
                n_idx  = '0;
                rd_idx = '0;
                if (len_rdata == '0) begin
                    if (is_ins) begin
                        n_carry = r_col;
                        n_pos   = '0;
                        n_state = ST_TAIL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (col_rdata == r_col) begin
                    // Already stored: report where, change nothing.
                    n_res_found = 1'b1;
                    n_res_pos   = r_idx;
                    n_state     = ST_DONE;
                end else if (col_rdata > r_col || last) begin
                    // Insertion point found: this slot, or past the end.
                    if (!is_ins) begin
                        n_state = ST_DONE;
                    end else if (row_is_full) begin
                        n_res_full = 1'b1;
                        n_state    = ST_DONE;
                    end else if (col_rdata > r_col) begin
                        // Overwrite this slot and carry its old column up.
                        col_we    = 1'b1;
                        col_wdata = r_col;
                        n_carry   = col_rdata;
                        n_pos     = r_idx;
                        n_idx     = idx1;
                        n_state   = last ? ST_TAIL : ST_SHIFT;
                    end else begin
                        // Append after the last stored column.
                        n_carry = r_col;
                        n_pos   = r_len;
                        n_idx   = r_len;
                        n_state = ST_TAIL;
                    end
                end else begin
                    n_idx = idx1;
                end
            end
            ST_SHIFT: begin
                // Write the carried column, pick up the one it displaces.
                col_we  = 1'b1;
                n_carry = col_rdata;
                n_idx   = idx1;
                if (last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                col_we    = 1'b1;
                len_we    = 1'b1;
                n_res_pos = r_pos;
                if (r_count != '1) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_row       <= n_row;
        r_col       <= n_col;
        r_base      <= n_base;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_carry     <= n_carry;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_res_full  <= n_res_full;
    end

    // Output register: load a finished result, hold it while stalled.
    assign pos_x = XPW'(r_res_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_pos   <= pos_x[POS_W-1:0];
            r_out_full  <= r_res_full;
            r_out_count <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_position      = r_out_pos;
    assign o_row_full      = r_out_full;
    assign o_nonzero_count = r_out_count;

endmodule

// File: hw/rtl/srpb_check.sv
// ============================================================================
// srpb_check: port-level checker for the sparse row pattern builder
// Watches the output channel and the consistency of delivered results.
// ============================================================================
module srpb_check import srpb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               o_found,
    input  logic [POS_W-1:0]   o_position,
    input  logic               o_row_full,
    input  t_count             o_nonzero_count
);

    logic   r_seen;
    t_count r_last_cnt;

    // Track the count of the last delivered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            r_last_cnt <= o_nonzero_count;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_found) && $stable(o_position)
            && $stable(o_row_full) && $stable(o_nonzero_count))
        else $error("stalled result changed");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_full |-> !o_found && o_position == '0)
        else $error("dropped insert reports a position or a hit");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen |-> o_nonzero_count >= r_last_cnt)
        else $error("entry count went down");

    a_count_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen && (o_found || o_row_full)
            |-> o_nonzero_count == r_last_cnt)
        else $error("hit or dropped insert changed the entry count");

endmodule

bind sparse_row_pattern_builder srpb_check u_srpb_check (.*);
